/* src/escape_time_fractal_iterator_unit_macros.svh */
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_UNIT_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ETF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ETF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/etf_pkg.sv */
`default_nettype none

package etf_pkg;

  typedef enum logic [1:0] {
    KIND_JULIA  = 2'd0,
    KIND_MANDEL = 2'd1,
    KIND_SHIP   = 2'd2,
    KIND_WEB    = 2'd3
  } kind_e;

  localparam logic [2:0] REG_KIND   = 3'd0;
  localparam logic [2:0] REG_LIMIT  = 3'd1;
  localparam logic [2:0] REG_STEPRE = 3'd2;
  localparam logic [2:0] REG_STEPIM = 3'd3;
  localparam logic [2:0] REG_MOVERE = 3'd4;
  localparam logic [2:0] REG_MOVEIM = 3'd5;
  localparam logic [2:0] REG_JULRE  = 3'd6;
  localparam logic [2:0] REG_JULIM  = 3'd7;

  // |z|^2 escape bound: 4 in Q16.48
  localparam logic [63:0] EscBound = 64'h0004_0000_0000_0000;

endpackage

`default_nettype wire

/* src/escape_time_fractal_iterator_unit.sv */
// after an accepted start the pixel is mapped in ST_MAP_RE, ST_MAP_IM and ST_MAP_SET; with a
// limit of 0 done_o follows ST_MAP_SET, else each iteration runs ST_SQ_RE, ST_SQ_IM, ST_CROSS,
// ST_WEB (web map only) and ST_UPDATE; one pixel at a time, no new start is taken while busy;
// one shared 32x32 multiplier does all products, one product per state, and so sets the pace
// busy is high from the cycle after start until done_o; a new start is taken in the done cycle
// reset: async active-low, config registers to their defaults, sequencer to idle
`default_nettype none
`include "escape_time_fractal_iterator_unit_macros.svh"

module escape_time_fractal_iterator_unit
  import etf_pkg::*;
#(
  parameter int WINDOW_WIDTH  = 1024,
  parameter int WINDOW_HEIGHT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // command side
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] pixel_x_i,
  input  wire logic [11:0] pixel_y_i,
  // result beat, one-cycle strobe
  output logic             done_o,
  output logic             escaped_o,
  output logic [15:0]      iter_count_o,
  output logic [31:0]      final_re_o,
  output logic [31:0]      final_im_o
);

  localparam int HalfW = WINDOW_WIDTH / 2;
  localparam int HalfH = WINDOW_HEIGHT / 2;

  // sequencer states: pixel mapping, then the iteration loop
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,   // dx * step_re
    ST_MAP_IM,   // dy * step_im, real coordinate finished
    ST_MAP_SET,  // load z and c
    ST_SQ_RE,    // re * re
    ST_SQ_IM,    // im * im
    ST_CROSS,    // re * im, escape test on the squares
    ST_WEB,      // ii * rr for the web map
    ST_UPDATE    // new z
  } state_e;

  // configuration registers
  kind_e        kind_q;
  logic [15:0]  limit_q;
  logic [30:0]  step_re_q;
  logic [30:0]  step_im_q;
  logic [31:0]  move_re_q;
  logic [31:0]  move_im_q;
  logic [31:0]  jul_re_q;
  logic [31:0]  jul_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_MANDEL;
      limit_q   <= 16'd64;
      step_re_q <= 31'd98304;
      step_im_q <= 31'd65536;
      move_re_q <= '0;
      move_im_q <= '0;
      jul_re_q  <= '0;
      jul_im_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KIND:   kind_q    <= kind_e'(cfg_data_i[1:0]);
        REG_LIMIT:  limit_q   <= cfg_data_i[15:0];
        REG_STEPRE: step_re_q <= cfg_data_i[30:0];
        REG_STEPIM: step_im_q <= cfg_data_i[30:0];
        REG_MOVERE: move_re_q <= cfg_data_i;
        REG_MOVEIM: move_im_q <= cfg_data_i;
        REG_JULRE:  jul_re_q  <= cfg_data_i;
        REG_JULIM:  jul_im_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and result registers
  state_e       state_q;
  logic         done_q;
  logic         escaped_q;
  logic [15:0]  count_q;
  logic [15:0]  iter_q;
  logic         first_q;
  logic [31:0]  fin_re_q;
  logic [31:0]  fin_im_q;

  // datapath registers
  logic [11:0]  px_q;
  logic [11:0]  py_q;
  logic [63:0]  p_q;      // multiplier output register
  logic [31:0]  pre_q;    // mapped real coordinate
  logic [31:0]  zr_q;
  logic [31:0]  zi_q;
  logic [31:0]  cr_q;
  logic [31:0]  ci_q;
  logic [63:0]  rr_q;     // exact re*re, Q16.48
  logic [63:0]  ii_q;     // exact im*im, Q16.48
  logic [63:0]  x_q;      // exact re*im, held while the web product runs

  // pixel offsets from the window center
  logic signed [13:0] dx;
  logic signed [13:0] dy;
  assign dx = $signed({2'b00, px_q}) - 14'(HalfW);
  assign dy = $signed({2'b00, py_q}) - 14'(HalfH);

  // the one shared multiplier
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  always_comb begin
    case (state_q)
      ST_MAP_RE: begin
        mul_a = {{18{dx[13]}}, dx};
        mul_b = {1'b0, step_re_q};
      end
      ST_MAP_IM: begin
        mul_a = {{18{dy[13]}}, dy};
        mul_b = {1'b0, step_im_q};
      end
      ST_SQ_RE: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      ST_SQ_IM: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      ST_WEB: begin
        mul_a = ii_q[55:24];
        mul_b = rr_q[55:24];
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // mapping results
  logic [31:0] pim;
  logic        c_is_point;
  assign pim        = p_q[31:0] + move_im_q;
  assign c_is_point = (kind_q == KIND_MANDEL) || (kind_q == KIND_SHIP);

  // escape test: the square of the im part sits in p_q during ST_CROSS
  logic [63:0] mag;
  logic        esc_hit;
  assign mag     = rr_q + p_q;
  assign esc_hit = !first_q && (mag > EscBound);

  // next z; during ST_UPDATE p_q holds re*im, or ii*rr for the web map
  logic [63:0] xprod;
  logic [63:0] xabs;
  logic [31:0] rr32;
  logic [31:0] ii32;
  logic [31:0] tt32;
  logic [31:0] nr;
  logic [31:0] ni;

  assign rr32  = rr_q[55:24];
  assign ii32  = ii_q[55:24];
  assign tt32  = p_q[55:24];
  assign xprod = (kind_q == KIND_WEB) ? x_q : p_q;
  assign xabs  = xprod[63] ? (64'd0 - xprod) : xprod;

  always_comb begin
    if (kind_q == KIND_WEB) begin
      nr = rr32 - {tt32[30:0], 1'b0} - ii32 + zr_q + zi_q + cr_q;
    end else begin
      nr = rr32 - ii32 + cr_q;
    end
    if (kind_q == KIND_SHIP) begin
      ni = xabs[54:23] + ci_q;
    end else begin
      ni = xprod[54:23] + ci_q;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    p_q <= mul_p;
    if (start && !busy) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    case (state_q)
      ST_MAP_IM: pre_q <= p_q[31:0] - move_re_q;
      ST_MAP_SET: begin
        if (c_is_point) begin
          cr_q <= pre_q;
          ci_q <= pim;
          zr_q <= '0;
          zi_q <= '0;
        end else begin
          cr_q <= jul_re_q;
          ci_q <= jul_im_q;
          zr_q <= pre_q;
          zi_q <= pim;
        end
      end
      ST_SQ_IM:  rr_q <= p_q;
      ST_CROSS:  ii_q <= p_q;
      ST_WEB:    x_q  <= p_q;
      ST_UPDATE: begin
        zr_q <= nr;
        zi_q <= ni;
      end
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      escaped_q <= 1'b0;
      count_q   <= '0;
      iter_q    <= '0;
      first_q   <= 1'b0;
      fin_re_q  <= '0;
      fin_im_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_MAP_RE;
          end
        end
        ST_MAP_RE: state_q <= ST_MAP_IM;
        ST_MAP_IM: state_q <= ST_MAP_SET;
        ST_MAP_SET: begin
          iter_q  <= '0;
          first_q <= 1'b1;
          if (limit_q == 16'd0) begin
            // nothing to iterate: report the starting z
            done_q    <= 1'b1;
            escaped_q <= 1'b0;
            count_q   <= '0;
            fin_re_q  <= c_is_point ? 32'd0 : pre_q;
            fin_im_q  <= c_is_point ? 32'd0 : pim;
            state_q   <= ST_IDLE;
          end else begin
            state_q <= ST_SQ_RE;
          end
        end
        ST_SQ_RE: state_q <= ST_SQ_IM;
        ST_SQ_IM: state_q <= ST_CROSS;
        ST_CROSS: begin
          if (esc_hit) begin
            done_q    <= 1'b1;
            escaped_q <= 1'b1;
            count_q   <= iter_q;
            fin_re_q  <= zr_q;
            fin_im_q  <= zi_q;
            state_q   <= ST_IDLE;
          end else if (!first_q && (iter_q + 16'd1 == limit_q)) begin
            // limit reached without escape
            done_q    <= 1'b1;
            escaped_q <= 1'b0;
            count_q   <= limit_q;
            fin_re_q  <= zr_q;
            fin_im_q  <= zi_q;
            state_q   <= ST_IDLE;
          end else begin
            if (!first_q) begin
              iter_q <= iter_q + 16'd1;
            end
            state_q <= (kind_q == KIND_WEB) ? ST_WEB : ST_UPDATE;
          end
        end
        ST_WEB: state_q <= ST_UPDATE;
        ST_UPDATE: begin
          first_q <= 1'b0;
          state_q <= ST_SQ_RE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign escaped_o    = escaped_q;
  assign iter_count_o = count_q;
  assign final_re_o   = fin_re_q;
  assign final_im_o   = fin_im_q;

  // a result beat only comes with the return to idle
  `ETF_ASSERT_SAME(a_done_idle, done_o, !busy, "result beat while busy")
  // an accepted start always launches the sequencer
  `ETF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start accepted but not busy")
  // the result strobe lasts one cycle
  `ETF_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")

endmodule

`default_nettype wire
